### hdl/chc_pkg.sv
// Shared types and constants for the census Hamming cost unit.
`timescale 1ns / 1ps
`default_nettype none

package chc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int MASK_W    = 49;
    localparam int COST_W    = 6;
    localparam int PIX_W     = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLUMNS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_ENABLE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_MASK   = 3'd5;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [COST_W-1:0] COST_MAX = 6'd48;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

endpackage

`default_nettype wire

### hdl/chc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module chc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 262144
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### hdl/census_hamming_cost_unit.sv
// Census transform stereo cost unit: image stores, window sequencer and Hamming count.
//
//  Channel  | Direction | Handshake                | Content
//  ---------+-----------+--------------------------+---------------------------------------
//  s        | in        | i_s_tvalid / o_s_tready  | pixel pair write or cost query item
//  m        | out       | o_m_tvalid / i_m_tready  | census cost of one query
//  cfg      | in        | i_cfg_valid / o_cfg_ready| register index and write data
//
// A write item leaves the input ready. A query item keeps the input busy while the centre pair
// is read, one window position follows per cycle, the clamp, address and read stages drain, and
// the output register loads. The input is ready again in the cycle the cost appears. Reset
// returns the sequencer to idle, sets the configuration to its defaults and clears the output
// valid flag; image contents are undefined until written.
// A stalled result holds in the output register; a finished query waits for it.
`timescale 1ns / 1ps
`default_nettype none

module census_hamming_cost_unit #(
    parameter int MAX_COLS = 512,
    parameter int MAX_ROWS = 512
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // pixel_column[8:0], pixel_row[17:9], left_value[25:18], right_value[33:26],
    // disparity[42:34], zero[47:43]
    input  wire logic [47:0]                    i_s_tdata,
    // action[0]
    input  wire logic                           i_s_tuser,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // census_cost[5:0], zero[7:6]
    output logic [7:0]                          o_m_tdata,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [chc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [chc_pkg::MASK_W-1:0]     i_cfg_data
);

    import chc_pkg::*;

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int AW    = $clog2(MAX_ROWS * MAX_COLS);
    localparam int YS    = RW + 2;
    localparam int XS    = CW + 2;
    localparam int DW    = ((CW > 9) ? CW : 9) + 2;
    localparam int DEPTH = MAX_ROWS * MAX_COLS;

    // Configuration registers.
    logic [9:0]        r_cols;
    logic [9:0]        r_rows;
    logic [2:0]        r_wh;
    logic [2:0]        r_ww;
    logic              r_mask_en;
    logic [MASK_W-1:0] r_mask;

    // Input fields.
    logic [8:0] w_col;
    logic [8:0] w_row;
    logic [7:0] w_lval;
    logic [7:0] w_rval;
    logic [8:0] w_disp;

    assign w_col  = i_s_tdata[8:0];
    assign w_row  = i_s_tdata[17:9];
    assign w_lval = i_s_tdata[25:18];
    assign w_rval = i_s_tdata[33:26];
    assign w_disp = i_s_tdata[42:34];

    t_state r_state;
    t_state n_state;

    logic [RW-1:0]       r_cy;
    logic [CW-1:0]       r_cx;
    logic [8:0]          r_disp;
    logic                r_first;
    logic signed [3:0]   r_dy;
    logic signed [3:0]   r_dx;
    logic [5:0]          r_bit;

    logic                r_a_vld;
    logic                r_a_ctr;
    logic                r_a_use;
    logic [RW-1:0]       r_a_y;
    logic [CW-1:0]       r_a_xl;

    logic                r_b_vld;
    logic                r_b_ctr;
    logic                r_b_use;
    logic [RW-1:0]       r_b_y;
    logic [CW-1:0]       r_b_xl;
    logic [CW-1:0]       r_b_xr;

    logic                r_c_vld;
    logic                r_c_ctr;
    logic                r_c_use;

    logic [PIX_W-1:0]    r_cl;
    logic [PIX_W-1:0]    r_cr;
    logic [COST_W-1:0]   r_cost;

    logic                r_out_vld;
    logic [COST_W-1:0]   r_out_data;

    logic [RW-1:0]       w_last_row;
    logic [CW-1:0]       w_last_col;
    logic [1:0]          w_hh;
    logic [1:0]          w_hw;
    logic signed [3:0]   w_hh_s;
    logic signed [3:0]   w_hw_s;
    logic                w_s_acc;
    logic                w_wr_en;
    logic [AW-1:0]       w_wr_addr;
    logic [AW-1:0]       w_rd_addr_l;
    logic [AW-1:0]       w_rd_addr_r;
    logic [PIX_W-1:0]    w_l_data;
    logic [PIX_W-1:0]    w_r_data;
    logic                w_use;
    logic                w_last_pos;
    logic signed [3:0]   w_off_y;
    logic signed [3:0]   w_off_x;
    logic signed [YS-1:0] w_ysum;
    logic signed [XS-1:0] w_xsum;
    logic [RW-1:0]       w_y;
    logic [CW-1:0]       w_x;
    logic signed [DW-1:0] w_xdiff;
    logic [CW-1:0]       w_xr;
    logic [RW-1:0]       w_cy_in;
    logic [CW-1:0]       w_cx_in;
    logic                w_out_free;

    // Sizes in use and half window sizes.
    always_comb begin
        if (r_rows == '0) begin
            w_last_row = '0;
        end else if (int'(r_rows) > MAX_ROWS) begin
            w_last_row = RW'(MAX_ROWS - 1);
        end else begin
            w_last_row = RW'(r_rows - 10'd1);
        end
        if (r_cols == '0) begin
            w_last_col = '0;
        end else if (int'(r_cols) > MAX_COLS) begin
            w_last_col = CW'(MAX_COLS - 1);
        end else begin
            w_last_col = CW'(r_cols - 10'd1);
        end
    end

    assign w_hh   = r_wh[2:1];
    assign w_hw   = r_ww[2:1];
    assign w_hh_s = $signed({2'b00, w_hh});
    assign w_hw_s = $signed({2'b00, w_hw});

    // Query centre clamped at acceptance.
    always_comb begin
        if (int'(w_row) > int'(w_last_row)) begin
            w_cy_in = w_last_row;
        end else begin
            w_cy_in = RW'(w_row);
        end
        if (int'(w_col) > int'(w_last_col)) begin
            w_cx_in = w_last_col;
        end else begin
            w_cx_in = CW'(w_col);
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_s_acc     = i_s_tvalid && o_s_tready;
    assign w_wr_en     = w_s_acc && (i_s_tuser == ACT_WRITE)
                         && (int'(w_row) < MAX_ROWS) && (int'(w_col) < MAX_COLS);
    assign w_wr_addr   = AW'(w_row) * AW'(MAX_COLS) + AW'(w_col);

    // Window position walk.
    assign w_use      = !r_first && !((r_dy == 4'sd0) && (r_dx == 4'sd0))
                        && (!r_mask_en || r_mask[r_bit]);
    assign w_last_pos = !r_first && (r_dy == w_hh_s) && (r_dx == w_hw_s);
    assign w_off_y    = r_first ? 4'sd0 : r_dy;
    assign w_off_x    = r_first ? 4'sd0 : r_dx;

    // Stage A: row and column clamped to the image edges.
    always_comb begin
        w_ysum = $signed({2'b00, r_cy}) + YS'(w_off_y);
        w_xsum = $signed({2'b00, r_cx}) + XS'(w_off_x);
        if (w_ysum < 0) begin
            w_y = '0;
        end else if (w_ysum > $signed({2'b00, w_last_row})) begin
            w_y = w_last_row;
        end else begin
            w_y = w_ysum[RW-1:0];
        end
        if (w_xsum < 0) begin
            w_x = '0;
        end else if (w_xsum > $signed({2'b00, w_last_col})) begin
            w_x = w_last_col;
        end else begin
            w_x = w_xsum[CW-1:0];
        end
    end

    // Stage B: right column shifted by the disparity and clamped at zero.
    always_comb begin
        w_xdiff = $signed({{(DW-CW){1'b0}}, r_a_xl}) - $signed({{(DW-9){1'b0}}, r_disp});
        if (w_xdiff < 0) begin
            w_xr = '0;
        end else begin
            w_xr = w_xdiff[CW-1:0];
        end
    end

    assign w_rd_addr_l = AW'(r_b_y) * AW'(MAX_COLS) + AW'(r_b_xl);
    assign w_rd_addr_r = AW'(r_b_y) * AW'(MAX_COLS) + AW'(r_b_xr);

    chc_ram #(
        .WIDTH(PIX_W),
        .DEPTH(DEPTH)
    ) u_left_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_lval),
        .i_rd_addr(w_rd_addr_l),
        .o_rd_data(w_l_data)
    );

    chc_ram #(
        .WIDTH(PIX_W),
        .DEPTH(DEPTH)
    ) u_right_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_rval),
        .i_rd_addr(w_rd_addr_r),
        .o_rd_data(w_r_data)
    );

    assign w_out_free = !r_out_vld || i_m_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_s_acc && (i_s_tuser == ACT_QUERY)) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (w_last_pos) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_a_vld && !r_b_vld && !r_c_vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            r_cols    <= 10'd512;
            r_rows    <= 10'd512;
            r_wh      <= 3'd7;
            r_ww      <= 3'd7;
            r_mask_en <= 1'b0;
            r_mask    <= '1;
        end else begin
            r_state <= n_state;
            r_a_vld <= (r_state == S_WALK);
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_IMAGE_COLUMNS: r_cols    <= i_cfg_data[9:0];
                    CFG_IMAGE_ROWS:    r_rows    <= i_cfg_data[9:0];
                    CFG_WINDOW_HEIGHT: r_wh      <= i_cfg_data[2:0] | 3'd1;
                    CFG_WINDOW_WIDTH:  r_ww      <= i_cfg_data[2:0] | 3'd1;
                    CFG_MASK_ENABLE:   r_mask_en <= i_cfg_data[0];
                    CFG_WINDOW_MASK:   r_mask    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_cy    <= w_cy_in;
            r_cx    <= w_cx_in;
            r_disp  <= w_disp;
            r_first <= 1'b1;
            r_dy    <= -w_hh_s;
            r_dx    <= -w_hw_s;
            r_bit   <= '0;
        end else if (r_state == S_WALK) begin
            r_first <= 1'b0;
            if (!r_first) begin
                r_bit <= r_bit + 6'd1;
                if (r_dx == w_hw_s) begin
                    r_dx <= -w_hw_s;
                    r_dy <= r_dy + 4'sd1;
                end else begin
                    r_dx <= r_dx + 4'sd1;
                end
            end
        end

        r_a_ctr <= r_first;
        r_a_use <= w_use;
        r_a_y   <= w_y;
        r_a_xl  <= w_x;

        r_b_ctr <= r_a_ctr;
        r_b_use <= r_a_use;
        r_b_y   <= r_a_y;
        r_b_xl  <= r_a_xl;
        r_b_xr  <= w_xr;

        r_c_ctr <= r_b_ctr;
        r_c_use <= r_b_use;

        if (w_s_acc) begin
            r_cost <= '0;
        end else if (r_c_vld) begin
            if (r_c_ctr) begin
                r_cl <= w_l_data;
                r_cr <= w_r_data;
            end else if (r_c_use && ((w_l_data > r_cl) != (w_r_data > r_cr))) begin
                r_cost <= r_cost + 6'd1;
            end
        end

        if ((r_state == S_DONE) && w_out_free) begin
            r_out_data <= r_cost;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {2'b00, r_out_data};

    a_cost_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_data <= COST_MAX))
        else $error("census cost above the window limit");

    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (!r_a_vld && !r_b_vld && !r_c_vld))
        else $error("result handed off with positions still in flight");

    a_centre_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_vld && r_c_ctr) |-> (r_cost == '0))
        else $error("centre pixel returned after counting began");

    a_walk_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_bit <= COST_MAX))
        else $error("window position counter overran the mask");

    a_done_from_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_DONE) |-> ($past(r_state) == S_DRAIN))
        else $error("result stage entered without draining");

endmodule

`default_nettype wire
